/* src/pitc_pkg.sv */
// pitc_pkg: shared types, constants and helper functions of the palette tile converter
// used by pitc_ctrl and palette_indexed_tile_converter; depends on nothing else
`timescale 1ns / 1ps
`default_nettype none

package pitc_pkg;

    localparam int PALETTE_DEPTH_DEF    = 256;
    localparam int FIRST_FREE_ENTRY_DEF = 16;
    localparam int PRESET_COUNT         = 16;

    localparam int ADDR_W   = 19;
    localparam int WIDTH_W  = 7;
    localparam int COLOR_W  = 24;
    localparam int COORD_W  = 9;

    localparam logic [WIDTH_W-1:0] WIDTH_TILES_RESET = 7'd40;
    localparam logic [ADDR_W-1:0]  PIXEL_BASE        = 19'h300;
    localparam logic [ADDR_W-1:0]  GREEN_OFFSET      = 19'h100;
    localparam logic [ADDR_W-1:0]  BLUE_OFFSET       = 19'h200;

    localparam logic REQ_PIXEL   = 1'b0;
    localparam logic REQ_READOUT = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [7:0]        data;
        logic              full;
        logic              last;
    } t_result;

    function automatic logic [7:0] swap_nibbles(input logic [7:0] v);
        swap_nibbles = {v[3:0], v[7:4]};
    endfunction

    function automatic logic [COLOR_W-1:0] preset_color(input logic [3:0] idx);
        logic [COLOR_W-1:0] c;
        unique case (idx)
            4'd0:    c = 24'h000000;
            4'd1:    c = 24'hFFFFFF;
            4'd2:    c = 24'hAB3126;
            4'd3:    c = 24'h66DAFF;
            4'd4:    c = 24'hBB3FB8;
            4'd5:    c = 24'h55CE58;
            4'd6:    c = 24'h1D0E97;
            4'd7:    c = 24'hEAF57C;
            4'd8:    c = 24'hB97418;
            4'd9:    c = 24'h787300;
            4'd10:   c = 24'hDD9387;
            4'd11:   c = 24'h5B5B5B;
            4'd12:   c = 24'h8B8B8B;
            4'd13:   c = 24'hB0F4AC;
            4'd14:   c = 24'hAA9DEF;
            default: c = 24'hB8B8B8;
        endcase
        preset_color = c;
    endfunction

endpackage

`default_nettype wire

/* src/pitc_pal_ram.sv */
// pitc_pal_ram: palette colour memory, one write and one registered read port
// no package dependency; instantiated by pitc_ctrl
`timescale 1ns / 1ps
`default_nettype none

module pitc_pal_ram #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 24,
    parameter int AW     = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [AW-1:0]     i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* src/pitc_ctrl.sv */
// pitc_ctrl: request sequencer, palette search and allocation, readout and address math
// depends on pitc_pkg and pitc_pal_ram
`timescale 1ns / 1ps
`default_nettype none

module pitc_ctrl
    import pitc_pkg::*;
#(
    parameter int PALETTE_DEPTH    = PALETTE_DEPTH_DEF,
    parameter int FIRST_FREE_ENTRY = FIRST_FREE_ENTRY_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_req_valid,
    output logic                    o_req_busy,
    input  wire logic               i_req_type,
    input  wire logic [7:0]         i_red,
    input  wire logic [7:0]         i_green,
    input  wire logic [7:0]         i_blue,
    input  wire logic [COORD_W-1:0] i_pixel_x,
    input  wire logic [COORD_W-1:0] i_pixel_y,
    input  wire logic [7:0]         i_entry_index,
    input  wire logic [WIDTH_W-1:0] i_width_tiles,
    output logic                    o_res_valid,
    input  wire logic               i_res_ready,
    output t_result                 o_res
);

    localparam int AW   = $clog2(PALETTE_DEPTH);
    localparam int NF_W = $clog2(PALETTE_DEPTH + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_RDREQ  = 3'd2;
    localparam logic [2:0] S_RDDAT  = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    localparam logic [NF_W-1:0] NF_FIRST = NF_W'(FIRST_FREE_ENTRY);
    localparam logic [NF_W-1:0] NF_DEPTH = NF_W'(PALETTE_DEPTH);

    logic [2:0]         r_state, n_state;
    logic               r_req, n_req;
    logic [COLOR_W-1:0] r_colour, n_colour;
    logic [COORD_W-1:0] r_x, n_x;
    logic [COORD_W-1:0] r_y, n_y;
    logic [7:0]         r_entry, n_entry;
    logic [NF_W-1:0]    r_idx, n_idx;
    logic               r_rd_vld, n_rd_vld;
    logic [NF_W-1:0]    r_rd_idx, n_rd_idx;
    logic [7:0]         r_byte, n_byte;
    logic               r_full, n_full;
    logic [1:0]         r_beat, n_beat;
    logic [NF_W-1:0]    r_nfree, n_nfree;

    logic               mem_we;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic [COLOR_W-1:0] mem_rdata;

    logic               hit;
    logic [12:0]        row_prod;
    logic [ADDR_W-1:0]  pixel_addr;
    logic [9:0]         entry_ext;

    pitc_pal_ram #(
        .DEPTH  (PALETTE_DEPTH),
        .DATA_W (COLOR_W),
        .AW     (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_nfree[AW-1:0]),
        .i_wdata (r_colour),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign hit       = r_rd_vld && (mem_rdata == r_colour);
    assign entry_ext = 10'(r_entry);

    // tile layout: low 12 bits are {tile column, row in tile, column in tile}
    assign row_prod   = 13'(r_y[COORD_W-1:3]) * 13'(i_width_tiles);
    assign pixel_addr = PIXEL_BASE + ADDR_W'({r_x[COORD_W-1:3], r_y[2:0], r_x[2:0]})
                      + {row_prod, 6'b0};

    assign o_req_busy = (r_state != S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_colour  = r_colour;
        n_x       = r_x;
        n_y       = r_y;
        n_entry   = r_entry;
        n_idx     = r_idx;
        n_rd_vld  = r_rd_vld;
        n_rd_idx  = r_rd_idx;
        n_byte    = r_byte;
        n_full    = r_full;
        n_beat    = r_beat;
        n_nfree   = r_nfree;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_raddr = r_idx[AW-1:0];
        o_res_valid     = 1'b0;
        o_res.address   = pixel_addr;
        o_res.data      = r_byte;
        o_res.full      = r_full;
        o_res.last      = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                n_rd_vld = 1'b0;
                if (i_req_valid) begin
                    n_req    = i_req_type;
                    n_colour = {i_red, i_green, i_blue};
                    n_x      = i_pixel_x;
                    n_y      = i_pixel_y;
                    n_entry  = i_entry_index;
                    n_idx    = NF_FIRST;
                    n_state  = (i_req_type == REQ_PIXEL) ? S_SEARCH : S_RDREQ;
                end
            end
            S_SEARCH: begin
                // one read issued per cycle, compared in the cycle after it is issued
                if (hit) begin
                    n_byte   = 8'(r_rd_idx);
                    n_full   = 1'b0;
                    n_rd_vld = 1'b0;
                    n_state  = S_EMIT;
                end else if (r_idx < r_nfree) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_idx[AW-1:0];
                    n_rd_idx  = r_idx;
                    n_idx     = r_idx + NF_W'(1);
                    n_rd_vld  = 1'b1;
                end else begin
                    n_rd_vld = 1'b0;
                    n_state  = S_EMIT;
                    if (r_nfree < NF_DEPTH) begin
                        mem_we  = 1'b1;
                        n_byte  = 8'(r_nfree);
                        n_full  = 1'b0;
                        n_nfree = r_nfree + NF_W'(1);
                    end else begin
                        n_byte = 8'd0;
                        n_full = 1'b1;
                    end
                end
            end
            S_RDREQ: begin
                mem_re    = 1'b1;
                mem_raddr = r_entry[AW-1:0];
                n_state   = S_RDDAT;
            end
            S_RDDAT: begin
                // entries never allocated read back their reset colour
                if (entry_ext >= 10'(PALETTE_DEPTH)) begin
                    n_colour = '0;
                end else if (entry_ext >= 10'(FIRST_FREE_ENTRY) && entry_ext < 10'(r_nfree)) begin
                    n_colour = mem_rdata;
                end else if (entry_ext < 10'(PRESET_COUNT)) begin
                    n_colour = preset_color(r_entry[3:0]);
                end else begin
                    n_colour = '0;
                end
                n_beat  = 2'd0;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                o_res_valid = 1'b1;
                if (r_req == REQ_READOUT) begin
                    o_res.full = 1'b0;
                    o_res.last = (r_beat == 2'd2);
                    unique case (r_beat)
                        2'd0: begin
                            o_res.address = ADDR_W'(r_entry);
                            o_res.data    = swap_nibbles(r_colour[23:16]);
                        end
                        2'd1: begin
                            o_res.address = ADDR_W'(r_entry) + GREEN_OFFSET;
                            o_res.data    = swap_nibbles(r_colour[15:8]);
                        end
                        default: begin
                            o_res.address = ADDR_W'(r_entry) + BLUE_OFFSET;
                            o_res.data    = swap_nibbles(r_colour[7:0]);
                        end
                    endcase
                end
                if (i_res_ready) begin
                    if (r_req == REQ_PIXEL || r_beat == 2'd2) begin
                        n_state = S_IDLE;
                    end else begin
                        n_beat = r_beat + 2'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_vld <= 1'b0;
            r_nfree  <= NF_FIRST;
            r_beat   <= 2'd0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= n_rd_vld;
            r_nfree  <= n_nfree;
            r_beat   <= n_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_colour <= n_colour;
        r_x      <= n_x;
        r_y      <= n_y;
        r_entry  <= n_entry;
        r_idx    <= n_idx;
        r_rd_idx <= n_rd_idx;
        r_byte   <= n_byte;
        r_full   <= n_full;
    end

`ifndef NO_ASSERTIONS
    a_nfree_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nfree >= NF_FIRST && r_nfree <= NF_DEPTH)
        else $error("fill count out of range");

    a_alloc_bumps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> r_nfree == $past(r_nfree) + NF_W'(1))
        else $error("allocation did not advance fill count");

    a_rd_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> r_state == S_SEARCH)
        else $error("search read pending outside search");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_res))
        else $error("result changed before it was taken");
`endif

endmodule

`default_nettype wire

/* src/palette_indexed_tile_converter.sv */
// Palette-indexed tile converter, top level.
// Input channel: i_valid/o_stall, one beat per request. req_type 0 converts an RGB
// pixel to a palette index, req_type 1 reads one palette entry back.
// Output channel: o_valid/i_stall. A pixel gives one beat (address in the 8x8
// tiled layout, index byte); a readout gives three beats of nibble-swapped colour,
// o_last marks the final beat of a request. o_palette_full flags a new colour
// that found no free entry (index 0 then).
// Config channel: i_cfg_valid/o_cfg_ready (always ready), width in tiles.
// A pixel is compared against each allocated entry in turn (one memory read per
// cycle, up to PALETTE_DEPTH - FIRST_FREE_ENTRY entries); a readout reads its
// entry, then gives one beat per cycle while i_stall is low. One request is in
// flight at a time: o_stall stays high until the last result beat has moved into
// the output register.
// Reset: synchronous, active low; palette back to the preset colours, fill count
// to the first free entry, width to 40, output register empty.
// Downstream stall holds the output register and, behind it, the sequencer.
// depends on pitc_pkg, pitc_ctrl, pitc_pal_ram
`timescale 1ns / 1ps
`default_nettype none

module palette_indexed_tile_converter
    import pitc_pkg::*;
#(
    parameter int PALETTE_DEPTH    = PALETTE_DEPTH_DEF,
    parameter int FIRST_FREE_ENTRY = FIRST_FREE_ENTRY_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_req_type,
    input  wire logic [7:0]         i_red,
    input  wire logic [7:0]         i_green,
    input  wire logic [7:0]         i_blue,
    input  wire logic [COORD_W-1:0] i_pixel_x,
    input  wire logic [COORD_W-1:0] i_pixel_y,
    input  wire logic [7:0]         i_entry_index,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [ADDR_W-1:0]       o_out_address,
    output logic [7:0]              o_out_byte,
    output logic                    o_palette_full,
    output logic                    o_last,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [WIDTH_W-1:0] i_cfg_width_tiles
);

    logic [WIDTH_W-1:0] r_width;
    logic               r_out_valid;
    t_result            r_out;
    logic               ctrl_busy;
    logic               res_valid;
    logic               res_ready;
    t_result            res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WIDTH_TILES_RESET;
        end else if (i_cfg_valid) begin
            r_width <= i_cfg_width_tiles;
        end
    end

    pitc_ctrl #(
        .PALETTE_DEPTH    (PALETTE_DEPTH),
        .FIRST_FREE_ENTRY (FIRST_FREE_ENTRY)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .o_req_busy    (ctrl_busy),
        .i_req_type    (i_req_type),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .i_entry_index (i_entry_index),
        .i_width_tiles (r_width),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res         (res)
    );

    assign o_stall = ctrl_busy;

    // output register frees when empty or when its beat is taken this cycle
    assign res_ready = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_address  = r_out.address;
    assign o_out_byte     = r_out.data;
    assign o_palette_full = r_out.full;
    assign o_last         = r_out.last;

endmodule

`default_nettype wire

/* test/palette_indexed_tile_converter_tb.sv */
// palette_indexed_tile_converter_tb: self-checking bench for the palette tile converter
// a directed table and random requests go through a shadow palette that predicts every beat
// depends on pitc_pkg and palette_indexed_tile_converter
`timescale 1ns / 1ps

module palette_indexed_tile_converter_tb;
    import pitc_pkg::*;

    localparam int ITEMS_PER_PHASE = 160;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int RX_HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES    = 300;
    localparam int DIR_ROWS        = 23;
    localparam int MAX_REPORTS     = 10;

    localparam logic [COLOR_W-1:0] PRESET_RGB [16] = '{
        24'h000000, 24'hFFFFFF, 24'hAB3126, 24'h66DAFF,
        24'hBB3FB8, 24'h55CE58, 24'h1D0E97, 24'hEAF57C,
        24'hB97418, 24'h787300, 24'hDD9387, 24'h5B5B5B,
        24'h8B8B8B, 24'hB0F4AC, 24'hAA9DEF, 24'hB8B8B8
    };

    typedef struct packed {
        logic               req;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [7:0]         entry;
    } t_conv_req;

    typedef enum logic {ROW_REQ, ROW_WIDTH} t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        logic               req;
        logic [COLOR_W-1:0] rgb;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [7:0]         entry;
        logic [WIDTH_W-1:0] width;
        logic               typed;
        logic [ADDR_W-1:0]  t_addr;
        logic [7:0]         t_byte;
    } t_dir_row;

    // typed rows carry the expected first beat
    t_dir_row dir_table [DIR_ROWS] = '{
        '{ROW_REQ,   REQ_READOUT, 24'h000000, 9'd0,   9'd0,   8'd0,   7'd0,   1'b1, 19'h0,     8'h00},
        '{ROW_REQ,   REQ_READOUT, 24'h000000, 9'd0,   9'd0,   8'd2,   7'd0,   1'b1, 19'h2,     8'hBA},
        '{ROW_REQ,   REQ_READOUT, 24'h000000, 9'd0,   9'd0,   8'd15,  7'd0,   1'b1, 19'hF,     8'h8B},
        '{ROW_REQ,   REQ_READOUT, 24'h000000, 9'd0,   9'd0,   8'd255, 7'd0,   1'b1, 19'hFF,    8'h00},
        '{ROW_REQ,   REQ_PIXEL,   24'h000000, 9'd0,   9'd0,   8'd0,   7'd0,   1'b1, 19'h300,   8'd16},
        '{ROW_REQ,   REQ_PIXEL,   24'hFFFFFF, 9'd511, 9'd511, 8'd255, 7'd0,   1'b1, 19'h288FF, 8'd17},
        '{ROW_REQ,   REQ_PIXEL,   24'h000000, 9'd8,   9'd8,   8'd0,   7'd0,   1'b0, 19'h0,     8'h00},
        '{ROW_REQ,   REQ_PIXEL,   24'hAB3126, 9'd7,   9'd7,   8'd0,   7'd0,   1'b0, 19'h0,     8'h00},
        '{ROW_REQ,   REQ_PIXEL,   24'h5A5A5A, 9'h155, 9'h0AA, 8'h55, 7'd0,   1'b0, 19'h0,     8'h00},
        '{ROW_REQ,   REQ_PIXEL,   24'hA5A5A5, 9'h0AA, 9'h155, 8'hAA, 7'd0,   1'b0, 19'h0,     8'h00},
        '{ROW_REQ,   REQ_READOUT, 24'h000000, 9'd0,   9'd0,   8'd16,  7'd0,   1'b0, 19'h0,     8'h00},
        '{ROW_REQ,   REQ_READOUT, 24'h000000, 9'd0,   9'd0,   8'd17,  7'd0,   1'b0, 19'h0,     8'h00},
        '{ROW_REQ,   REQ_READOUT, 24'h000000, 9'd0,   9'd0,   8'd18,  7'd0,   1'b0, 19'h0,     8'h00},
        '{ROW_WIDTH, REQ_PIXEL,   24'h000000, 9'd0,   9'd0,   8'd0,   7'd0,   1'b0, 19'h0,     8'h00},
        '{ROW_REQ,   REQ_PIXEL,   24'hFFFFFF, 9'd511, 9'd511, 8'd0,   7'd0,   1'b1, 19'h12FF,  8'd17},
        '{ROW_WIDTH, REQ_PIXEL,   24'h000000, 9'd0,   9'd0,   8'd0,   7'd127, 1'b0, 19'h0,     8'h00},
        '{ROW_REQ,   REQ_PIXEL,   24'h123456, 9'd511, 9'd511, 8'd0,   7'd0,   1'b1, 19'h7E33F, 8'd21},
        '{ROW_REQ,   REQ_PIXEL,   24'h123456, 9'd0,   9'd8,   8'd0,   7'd0,   1'b0, 19'h0,     8'h00},
        '{ROW_WIDTH, REQ_PIXEL,   24'h000000, 9'd0,   9'd0,   8'd0,   7'd1,   1'b0, 19'h0,     8'h00},
        '{ROW_REQ,   REQ_PIXEL,   24'h654321, 9'd0,   9'd511, 8'd0,   7'd0,   1'b0, 19'h0,     8'h00},
        '{ROW_WIDTH, REQ_PIXEL,   24'h000000, 9'd0,   9'd0,   8'd0,   7'd64,  1'b0, 19'h0,     8'h00},
        '{ROW_REQ,   REQ_PIXEL,   24'h000000, 9'd511, 9'd0,   8'd0,   7'd0,   1'b0, 19'h0,     8'h00},
        '{ROW_REQ,   REQ_READOUT, 24'h000000, 9'd0,   9'd0,   8'd21,  7'd0,   1'b0, 19'h0,     8'h00}
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_req_type = 1'b0;
    logic [7:0]         i_red = '0;
    logic [7:0]         i_green = '0;
    logic [7:0]         i_blue = '0;
    logic [COORD_W-1:0] i_pixel_x = '0;
    logic [COORD_W-1:0] i_pixel_y = '0;
    logic [7:0]         i_entry_index = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [ADDR_W-1:0]  o_out_address;
    logic [7:0]         o_out_byte;
    logic               o_palette_full;
    logic               o_last;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [WIDTH_W-1:0] i_cfg_width_tiles = '0;

    // shadow copy of the block state
    logic [COLOR_W-1:0] shadow_palette [256];
    int unsigned        fill_level;
    logic [WIDTH_W-1:0] tile_width;

    t_result beats_owed [$];

    int  tx_idle_pct = 0;
    int  rx_stall_pct = 0;
    logic hold_armed = 1'b0;
    logic hold_active = 1'b0;

    int  fail_count = 0;
    int  requests_sent = 0;
    int  readouts_sent = 0;
    int  beats_checked = 0;
    int  full_beats = 0;

    palette_indexed_tile_converter dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_req_type        (i_req_type),
        .i_red             (i_red),
        .i_green           (i_green),
        .i_blue            (i_blue),
        .i_pixel_x         (i_pixel_x),
        .i_pixel_y         (i_pixel_y),
        .i_entry_index     (i_entry_index),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_out_address     (o_out_address),
        .o_out_byte        (o_out_byte),
        .o_palette_full    (o_palette_full),
        .o_last            (o_last),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_width_tiles (i_cfg_width_tiles)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // looks up or allocates the colour, or reads an entry, and queues the beats it owes
    task automatic resolve_request(input t_conv_req q);
        logic [COLOR_W-1:0] colour;
        logic [7:0]         part;
        t_result            b;
        int unsigned        hit;
        int unsigned        addr;
        bit                 found;
        if (q.req == REQ_PIXEL) begin
            colour = {q.red, q.green, q.blue};
            found = 1'b0;
            hit = 0;
            b.full = 1'b0;
            // presets below the first free entry are never searched
            for (int i = FIRST_FREE_ENTRY_DEF; i < fill_level && !found; i++) begin
                if (shadow_palette[i] == colour) begin
                    hit = i;
                    found = 1'b1;
                end
            end
            if (!found) begin
                if (fill_level < PALETTE_DEPTH_DEF) begin
                    shadow_palette[fill_level] = colour;
                    hit = fill_level;
                    fill_level++;
                end else begin
                    hit = 0;
                    b.full = 1'b1;
                end
            end
            addr = PIXEL_BASE + q.x[2:0] + q.y[2:0] * 8 + q.x[8:3] * 64
                 + q.y[8:3] * 64 * tile_width;
            b.address = addr[ADDR_W-1:0];
            b.data = hit[7:0];
            b.last = 1'b1;
            beats_owed.push_back(b);
        end else begin
            colour = shadow_palette[q.entry];
            for (int k = 0; k < 3; k++) begin
                part = colour[23 - 8 * k -: 8];
                b.address = {9'd0, k[1:0], q.entry};
                b.data = {part[3:0], part[7:4]};
                b.full = 1'b0;
                b.last = (k == 2);
                beats_owed.push_back(b);
            end
        end
    endtask

    task automatic offer(input t_conv_req q, input logic typed,
                         input logic [ADDR_W-1:0] t_addr, input logic [7:0] t_byte);
        int first;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= q.req;
        i_red <= q.red;
        i_green <= q.green;
        i_blue <= q.blue;
        i_pixel_x <= q.x;
        i_pixel_y <= q.y;
        i_entry_index <= q.entry;
        do @(posedge i_clk); while (o_stall);
        first = beats_owed.size();
        resolve_request(q);
        if (typed) begin
            beats_owed[first].address = t_addr;
            beats_owed[first].data = t_byte;
        end
        requests_sent++;
        if (q.req == REQ_READOUT)
            readouts_sent++;
    endtask

    task automatic write_width(input logic [WIDTH_W-1:0] w);
        while (beats_owed.size() != 0)
            @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_width_tiles <= w;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tile_width = w;
    endtask

    function automatic t_conv_req pick_request();
        t_conv_req   q;
        int unsigned sel;
        q.red = 8'($urandom_range(255));
        q.green = 8'($urandom_range(255));
        q.blue = 8'($urandom_range(255));
        q.x = COORD_W'($urandom_range(511));
        q.y = COORD_W'($urandom_range(511));
        q.entry = 8'($urandom_range(255));
        if ($urandom_range(99) < 12) begin
            q.req = REQ_READOUT;
            if ($urandom_range(1) == 1)
                q.entry = 8'($urandom_range(fill_level - 1, FIRST_FREE_ENTRY_DEF));
        end else begin
            q.req = REQ_PIXEL;
            sel = $urandom_range(99);
            // mostly new colours so the palette fills up partway through
            if (sel < 22 && fill_level > FIRST_FREE_ENTRY_DEF)
                {q.red, q.green, q.blue} =
                    shadow_palette[$urandom_range(fill_level - 1, FIRST_FREE_ENTRY_DEF)];
            else if (sel < 28)
                {q.red, q.green, q.blue} = PRESET_RGB[$urandom_range(15)];
        end
        return q;
    endfunction

    always @(posedge i_clk)
        i_stall <= hold_active || ($urandom_range(99) < rx_stall_pct);

    // long downstream hold so the block backs up into its input
    initial begin : rx_hold
        wait (hold_armed);
        hold_active <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge i_clk);
        hold_active <= 1'b0;
    end

    always @(posedge i_clk) begin : beat_check
        t_result want;
        t_result got;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_out_address, o_out_byte, o_palette_full, o_last};
            beats_checked++;
            if (o_palette_full)
                full_beats++;
            if (beats_owed.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected beat: addr %h byte %h full %b last %b",
                             got.address, got.data, got.full, got.last);
            end else begin
                want = beats_owed.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display({"mismatch: want addr %h byte %h full %b last %b,",
                                  " got addr %h byte %h full %b last %b"},
                                 want.address, want.data, want.full, want.last,
                                 got.address, got.data, got.full, got.last);
                end
            end
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("FAIL palette_indexed_tile_converter");
        $finish;
    end

    initial begin : stimulus
        t_conv_req q;
        for (int i = 0; i < 256; i++)
            shadow_palette[i] = (i < PRESET_COUNT) ? PRESET_RGB[i] : '0;
        fill_level = FIRST_FREE_ENTRY_DEF;
        tile_width = WIDTH_TILES_RESET;

        tx_idle_pct = 21;
        rx_stall_pct <= 57;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_table[r]) begin
            if (dir_table[r].kind == ROW_WIDTH) begin
                i_valid <= 1'b0;
                write_width(dir_table[r].width);
            end else begin
                q.req = dir_table[r].req;
                {q.red, q.green, q.blue} = dir_table[r].rgb;
                q.x = dir_table[r].x;
                q.y = dir_table[r].y;
                q.entry = dir_table[r].entry;
                offer(q, dir_table[r].typed, dir_table[r].t_addr, dir_table[r].t_byte);
            end
        end

        for (int ph = 0; ph < 3; ph++) begin
            i_valid <= 1'b0;
            write_width((ph == 1) ? WIDTH_W'($urandom_range(127))
                                  : WIDTH_W'($urandom_range(64, 1)));
            tx_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 57 : 0;
            rx_stall_pct <= (ph == 0) ? 57 : (ph == 1) ? 21 : 0;
            if (ph == 2)
                hold_armed <= 1'b1;
            repeat (ITEMS_PER_PHASE)
                offer(pick_request(), 1'b0, '0, '0);
        end
        i_valid <= 1'b0;

        while (beats_owed.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests (%0d readouts), %0d beats checked, %0d entries allocated",
                 requests_sent, readouts_sent, beats_checked, fill_level - FIRST_FREE_ENTRY_DEF);
        $display("%0d pixels met a full palette; widths 0, 1, 64, 127 and random strides used",
                 full_beats);
        if (fail_count == 0 && beats_owed.size() == 0)
            $display("PASS palette_indexed_tile_converter");
        else
            $display("FAIL palette_indexed_tile_converter");
        $finish;
    end

endmodule

/* filelist.f */
src/pitc_pkg.sv
src/pitc_pal_ram.sv
src/pitc_ctrl.sv
src/palette_indexed_tile_converter.sv
test/palette_indexed_tile_converter_tb.sv
